FILE: hw/rtl/voa_pkg.sv
// ----------------------------------------------------------------------------
// voa_pkg
// Shared types and constants for the voxel occupancy accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package voa_pkg;

   localparam int GRID_CELLS  = 65536;
   localparam int GRID_AW     = $clog2(GRID_CELLS);
   localparam int QUEUE_DEPTH = 4096;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int PEND_W      = QUEUE_AW + 1;
   localparam int COUNT_WIDTH = 32;
   localparam int TOTAL_W     = 48;
   localparam int CFG_W       = 17;
   localparam int COORD_W     = 16;
   localparam int PROD_W      = 32;
   localparam int SUM_W       = PROD_W + 1;
   localparam int DIST_W      = 13;
   localparam int CMDQ_DEPTH  = 4;
   localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
   localparam int CSR_AW      = 4;

   localparam logic [TOTAL_W-1:0]     TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // request kinds on req_tuser
   localparam logic [1:0] REQ_MARK   = 2'd0;
   localparam logic [1:0] REQ_CLOSE  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // result status codes on rsp_tuser
   localparam logic [2:0] STS_NEW   = 3'd0;
   localparam logic [2:0] STS_DUP   = 3'd1;
   localparam logic [2:0] STS_NEG   = 3'd2;
   localparam logic [2:0] STS_OUT   = 3'd3;
   localparam logic [2:0] STS_FULL  = 3'd4;
   localparam logic [2:0] STS_CLOSE = 3'd5;
   localparam logic [2:0] STS_EMPTY = 3'd6;
   localparam logic [2:0] STS_READ  = 3'd7;

   // register indexes
   localparam logic [1:0] CSR_CELLS = 2'd0;
   localparam logic [1:0] CSR_LINE  = 2'd1;
   localparam logic [1:0] CSR_PLANE = 2'd2;

   typedef enum logic [2:0] {
      CMD_MARK,
      CMD_NEG,
      CMD_OUT,
      CMD_CLOSE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [GRID_AW-1:0]   index;
   } cmd_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [15:0]            index;
      logic [31:0]            count;
      logic [DIST_W-1:0]      distinct;
      logic [TOTAL_W-1:0]     total;
   } rsp_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } back_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/voa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// voa_cmd_fifo
// Short command queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module voa_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  voa_pkg::cmd_type push_cmd,
   input  logic             pop,
   output voa_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);

   voa_pkg::cmd_type             mem [voa_pkg::CMDQ_DEPTH];
   logic [voa_pkg::CMDQ_AW-1:0]  wr_ff, wr_in;
   logic [voa_pkg::CMDQ_AW-1:0]  rd_ff, rd_in;
   logic [voa_pkg::CMDQ_AW:0]    cnt_ff, cnt_in;
   logic                         do_push, do_pop;

   assign full    = (cnt_ff == (voa_pkg::CMDQ_AW+1)'(voa_pkg::CMDQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/voa_front.sv
// ----------------------------------------------------------------------------
// voa_front
// Accepts requests, computes the linear index and classifies marks.
// ----------------------------------------------------------------------------
`default_nettype none

module voa_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [63:0]                 req_tdata,
   input  logic [1:0]                  req_tuser,
   input  logic [voa_pkg::CFG_W-1:0]   cells_in_use,
   input  logic [voa_pkg::CFG_W-1:0]   line_stride,
   input  logic [voa_pkg::CFG_W-1:0]   plane_stride,
   input  voa_pkg::back_stat_type      stat,
   input  logic                        fifo_full,
   output logic                        push,
   output voa_pkg::cmd_type            push_cmd
);

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM} fstate_type;

   fstate_type                          state_ff, state_in;
   logic [1:0]                          type_ff, type_in;
   logic [voa_pkg::COORD_W-1:0]         u_ff, u_in, v_ff, v_in, t_ff, t_in, ri_ff, ri_in;
   logic [voa_pkg::PROD_W-1:0]          pu_ff, pu_in, pv_ff, pv_in;
   logic                                neg_ff, neg_in;
   logic [voa_pkg::SUM_W-1:0]           sum;
   logic [voa_pkg::CFG_W-1:0]           limit;
   logic                                outside;

   assign req_tready = (state_ff == F_IDLE) && !stat.clearing;

   assign limit = (cells_in_use < voa_pkg::CFG_W'(voa_pkg::GRID_CELLS)) ?
                  cells_in_use : voa_pkg::CFG_W'(voa_pkg::GRID_CELLS);
   assign sum = voa_pkg::SUM_W'(pu_ff) + voa_pkg::SUM_W'(pv_ff)
              + voa_pkg::SUM_W'(t_ff[voa_pkg::COORD_W-2:0]);
   assign outside = (sum >= voa_pkg::SUM_W'(limit));

   always_comb begin
      state_in = state_ff;
      type_in  = type_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      t_in     = t_ff;
      ri_in    = ri_ff;
      pu_in    = pu_ff;
      pv_in    = pv_ff;
      neg_in   = neg_ff;
      push     = 1'b0;
      push_cmd = '{kind: voa_pkg::CMD_CLOSE, index: '0};
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid && req_tready) begin
               type_in  = req_tuser;
               u_in     = req_tdata[15:0];
               v_in     = req_tdata[31:16];
               t_in     = req_tdata[47:32];
               ri_in    = req_tdata[63:48];
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            // coordinates are only used when non-negative, so 15 bits suffice
            pu_in  = voa_pkg::PROD_W'(u_ff[voa_pkg::COORD_W-2:0]) *
                     voa_pkg::PROD_W'(plane_stride);
            pv_in  = voa_pkg::PROD_W'(v_ff[voa_pkg::COORD_W-2:0]) *
                     voa_pkg::PROD_W'(line_stride);
            neg_in = u_ff[voa_pkg::COORD_W-1] | v_ff[voa_pkg::COORD_W-1] |
                     t_ff[voa_pkg::COORD_W-1];
            if (type_ff == voa_pkg::REQ_MARK || type_ff == voa_pkg::REQ_CLOSE ||
                type_ff == voa_pkg::REQ_READ) begin
               state_in = F_SUM;
            end else begin
               state_in = F_IDLE;
            end
         end
         F_SUM: begin
            case (type_ff)
               voa_pkg::REQ_MARK: begin
                  push_cmd.index = sum[voa_pkg::GRID_AW-1:0];
                  if (neg_ff) begin
                     push_cmd.kind = voa_pkg::CMD_NEG;
                  end else if (outside) begin
                     push_cmd.kind = voa_pkg::CMD_OUT;
                  end else begin
                     push_cmd.kind = voa_pkg::CMD_MARK;
                  end
               end
               voa_pkg::REQ_READ: begin
                  push_cmd.kind  = voa_pkg::CMD_READ;
                  push_cmd.index = ri_ff;
               end
               default: begin
                  push_cmd.kind = voa_pkg::CMD_CLOSE;
               end
            endcase
            if (!fifo_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      type_ff <= type_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      t_ff    <= t_in;
      ri_ff   <= ri_in;
      pu_ff   <= pu_in;
      pv_ff   <= pv_in;
      neg_ff  <= neg_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/voa_back.sv
// ----------------------------------------------------------------------------
// voa_back
// Executes commands against the touched map, pending queue and count memory.
// ----------------------------------------------------------------------------
`default_nettype none

module voa_back (
   input  logic                    clock,
   input  logic                    reset,
   input  voa_pkg::cmd_type        head,
   input  logic                    fifo_empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output voa_pkg::rsp_type        rsp,
   output voa_pkg::back_stat_type  stat
);

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_MARK_EVAL, B_READ_EVAL, B_WALK_Q, B_WALK_C, B_WALK_W
   } bstate_type;

   localparam int AW = voa_pkg::GRID_AW;
   localparam int CW = voa_pkg::COUNT_WIDTH;

   logic                          touched_mem [voa_pkg::GRID_CELLS];
   logic [CW-1:0]                 count_mem   [voa_pkg::GRID_CELLS];
   logic [AW-1:0]                 queue_mem   [voa_pkg::QUEUE_DEPTH];

   bstate_type                    state_ff, state_in;
   voa_pkg::cmd_type              cmd_ff, cmd_in;
   logic [voa_pkg::PEND_W-1:0]    pend_ff, pend_in, walk_ff, walk_in;
   logic [voa_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic [AW-1:0]                 widx_ff, widx_in, clr_ff, clr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   voa_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          t_rd_ff;
   logic [CW-1:0]                 c_rd_ff;
   logic [AW-1:0]                 q_rd_ff;
   logic [AW-1:0]                 t_waddr, c_waddr, c_raddr;
   logic                          t_we, t_wdata, c_we, q_we;
   logic [CW-1:0]                 c_wdata;
   logic [voa_pkg::TOTAL_W-1:0]   total_next;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;
   assign stat.clearing = (state_ff == B_CLEAR);
   assign stat.idle     = (state_ff == B_IDLE);
   assign c_raddr       = (state_ff == B_WALK_C) ? q_rd_ff : head.index;

   assign total_next = (total_ff > voa_pkg::TOTAL_MAX - voa_pkg::TOTAL_W'(pend_ff)) ?
                       voa_pkg::TOTAL_MAX : total_ff + voa_pkg::TOTAL_W'(pend_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pend_in      = pend_ff;
      walk_in      = walk_ff;
      total_in     = total_ff;
      widx_in      = widx_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      t_we         = 1'b0;
      t_waddr      = cmd_ff.index;
      t_wdata      = 1'b0;
      c_we         = 1'b0;
      c_waddr      = widx_ff;
      c_wdata      = '0;
      q_we         = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff;
            c_we    = 1'b1;
            c_waddr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == {AW{1'b1}}) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!fifo_empty && !rsp_valid_ff) begin
               pop    = 1'b1;
               cmd_in = head;
               rsp_in = '0;
               unique case (head.kind)
                  voa_pkg::CMD_MARK: state_in = B_MARK_EVAL;
                  voa_pkg::CMD_READ: state_in = B_READ_EVAL;
                  voa_pkg::CMD_NEG: begin
                     rsp_in.status = voa_pkg::STS_NEG;
                     rsp_valid_in  = 1'b1;
                  end
                  voa_pkg::CMD_OUT: begin
                     rsp_in.status = voa_pkg::STS_OUT;
                     rsp_valid_in  = 1'b1;
                  end
                  voa_pkg::CMD_CLOSE: begin
                     if (pend_ff == '0) begin
                        rsp_in.status = voa_pkg::STS_EMPTY;
                        rsp_in.total  = total_ff;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        walk_in  = '0;
                        state_in = B_WALK_Q;
                     end
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_MARK_EVAL: begin
            rsp_in.index = cmd_ff.index;
            rsp_valid_in = 1'b1;
            state_in     = B_IDLE;
            if (t_rd_ff) begin
               rsp_in.status = voa_pkg::STS_DUP;
            end else if (pend_ff == voa_pkg::PEND_W'(voa_pkg::QUEUE_DEPTH)) begin
               rsp_in.status = voa_pkg::STS_FULL;
            end else begin
               t_we          = 1'b1;
               t_wdata       = 1'b1;
               q_we          = 1'b1;
               pend_in       = pend_ff + 1'b1;
               rsp_in.status = voa_pkg::STS_NEW;
            end
         end
         B_READ_EVAL: begin
            rsp_in.status = voa_pkg::STS_READ;
            rsp_in.index  = cmd_ff.index;
            rsp_in.count  = 32'(c_rd_ff);
            rsp_valid_in  = 1'b1;
            state_in      = B_IDLE;
         end
         B_WALK_Q: begin
            state_in = B_WALK_C;
         end
         B_WALK_C: begin
            widx_in  = q_rd_ff;
            state_in = B_WALK_W;
         end
         B_WALK_W: begin
            c_we    = 1'b1;
            c_wdata = (c_rd_ff == voa_pkg::COUNT_MAX) ? c_rd_ff : c_rd_ff + 1'b1;
            t_we    = 1'b1;
            t_waddr = widx_ff;
            walk_in = walk_ff + 1'b1;
            if (walk_in == pend_ff) begin
               total_in        = total_next;
               pend_in         = '0;
               rsp_in.status   = voa_pkg::STS_CLOSE;
               rsp_in.distinct = voa_pkg::DIST_W'(pend_ff);
               rsp_in.total    = total_next;
               rsp_valid_in    = 1'b1;
               state_in        = B_IDLE;
            end else begin
               state_in = B_WALK_Q;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         touched_mem[t_waddr] <= t_wdata;
      end
      t_rd_ff <= touched_mem[head.index];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         count_mem[c_waddr] <= c_wdata;
      end
      c_rd_ff <= count_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[pend_ff[voa_pkg::QUEUE_AW-1:0]] <= cmd_ff.index;
      end
      q_rd_ff <= queue_mem[walk_ff[voa_pkg::QUEUE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         pend_ff      <= '0;
         total_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      walk_ff <= walk_in;
      widx_ff <= widx_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/voxel_occupancy_accumulator_top.sv
// ----------------------------------------------------------------------------
// voxel_occupancy_accumulator_top
// Per-cycle voxel touch histogram with duplicate filtering and running totals.
// ----------------------------------------------------------------------------
// Rejects and empty closes are answered by the back end directly; marks and reads take an evaluate state.
// A close walks each queued voxel in turn: queue read, count read, write back.
// The front end takes no new request until it is through with the last (index multiply, then add/compare).
// Reset: a clearing pass over all 65536 cells zeroes the touched map and counts;
// req_tready stays low until it ends. Configuration writes are taken throughout.
`default_nettype none

module voxel_occupancy_accumulator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [63:0]                 req_tdata,   // u_coord, v_coord, t_coord, read_index
   input  logic [1:0]                  req_tuser,   // req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [111:0]                rsp_tdata,   // voxel_index, voxel_count,
                                                    // cycle_distinct, total_touches, pad
   output logic [2:0]                  rsp_tuser,   // status
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [voa_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic [voa_pkg::CFG_W-1:0]  cells_ff, line_ff, plane_ff;
   logic                       csr_wr;
   logic [1:0]                 csr_sel;
   voa_pkg::back_stat_type     stat;
   voa_pkg::cmd_type           push_cmd, head;
   logic                       push, pop, fifo_full, fifo_empty;
   voa_pkg::rsp_type           rsp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[3:2];

   always_comb begin
      case (csr_sel)
         voa_pkg::CSR_CELLS: csr_prdata = 32'(cells_ff);
         voa_pkg::CSR_LINE:  csr_prdata = 32'(line_ff);
         voa_pkg::CSR_PLANE: csr_prdata = 32'(plane_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= voa_pkg::CFG_W'(65536);
         line_ff  <= voa_pkg::CFG_W'(256);
         plane_ff <= voa_pkg::CFG_W'(65536);
      end else if (csr_wr) begin
         case (csr_sel)
            voa_pkg::CSR_CELLS: cells_ff <= csr_pwdata[voa_pkg::CFG_W-1:0];
            voa_pkg::CSR_LINE:  line_ff  <= csr_pwdata[voa_pkg::CFG_W-1:0];
            voa_pkg::CSR_PLANE: plane_ff <= csr_pwdata[voa_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   voa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .cells_in_use (cells_ff),
      .line_stride  (line_ff),
      .plane_stride (plane_ff),
      .stat         (stat),
      .fifo_full    (fifo_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   voa_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   voa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp),
      .stat       (stat)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {3'b000, rsp.total, rsp.distinct, rsp.count, rsp.index};

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_tready)
      else $error("request accepted during clearing pass");

   a_close_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == voa_pkg::STS_CLOSE) |-> rsp_tdata[60:48] != '0)
      else $error("recorded cycle with no distinct voxels");

   a_count_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != voa_pkg::STS_READ) |-> rsp_tdata[47:16] == '0)
      else $error("count reported on a non-read transaction");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (stat.idle && !fifo_empty && !rsp_tvalid))
      else $error("command popped while back end busy");

endmodule

`default_nettype wire

FILE: dv/voa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voa_checker
// Watches the request, result and register ports of the voxel occupancy
// accumulator, keeps its own copy of the histogram state, predicts every
// result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module voa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [63:0]                   req_tdata,
   input  logic [1:0]                    req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [111:0]                  rsp_tdata,
   input  logic [2:0]                    rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [voa_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   input  logic                          csr_pready,
   output int                            outstanding,
   output int                            failures,
   output int                            closes_seen
);

   typedef struct packed {
      logic [2:0]                  status;
      logic [15:0]                 index;
      logic [31:0]                 count;
      logic [voa_pkg::DIST_W-1:0]  distinct;
      logic [voa_pkg::TOTAL_W-1:0] total;
   } voxel_result_type;

   logic [16:0]                 cells_cfg, line_cfg, plane_cfg;
   bit                          touched [voa_pkg::GRID_CELLS];
   logic [31:0]                 hist [voa_pkg::GRID_CELLS];
   int unsigned                 pending [$];
   logic [voa_pkg::TOTAL_W-1:0] total_sum;
   voxel_result_type            expected_results [$];

   function automatic voxel_result_type predict_voxel(logic [1:0] kind, logic [63:0] d);
      voxel_result_type   r;
      longint             u, v, t;
      longint unsigned    idx, lim;
      int unsigned        n;
      r = '0;
      case (kind)
         voa_pkg::REQ_MARK: begin
            u = $signed(d[15:0]);
            v = $signed(d[31:16]);
            t = $signed(d[47:32]);
            if (u < 0 || v < 0 || t < 0) begin
               r.status = voa_pkg::STS_NEG;
            end else begin
               idx = u * plane_cfg + v * line_cfg + t;
               lim = (cells_cfg < voa_pkg::GRID_CELLS) ? cells_cfg : voa_pkg::GRID_CELLS;
               if (idx >= lim) begin
                  r.status = voa_pkg::STS_OUT;
               end else if (touched[idx]) begin
                  r.status = voa_pkg::STS_DUP;
                  r.index  = idx[15:0];
               end else if (pending.size() >= voa_pkg::QUEUE_DEPTH) begin
                  r.status = voa_pkg::STS_FULL;
                  r.index  = idx[15:0];
               end else begin
                  touched[idx] = 1'b1;
                  pending.insert(pending.size(), int'(idx));
                  r.status = voa_pkg::STS_NEW;
                  r.index  = idx[15:0];
               end
            end
         end
         voa_pkg::REQ_CLOSE: begin
            n = pending.size();
            if (n == 0) begin
               r.status = voa_pkg::STS_EMPTY;
               r.total  = total_sum;
            end else begin
               foreach (pending[i]) begin
                  if (hist[pending[i]] != voa_pkg::COUNT_MAX) hist[pending[i]]++;
                  touched[pending[i]] = 1'b0;
               end
               if (total_sum > voa_pkg::TOTAL_MAX - n) total_sum = voa_pkg::TOTAL_MAX;
               else total_sum = total_sum + n;
               pending.delete();
               r.status   = voa_pkg::STS_CLOSE;
               r.distinct = (n > 8191) ? 13'd8191 : n[voa_pkg::DIST_W-1:0];
               r.total    = total_sum;
            end
         end
         default: begin
            r.status = voa_pkg::STS_READ;
            r.index  = d[63:48];
            r.count  = hist[d[63:48]];
         end
      endcase
      return r;
   endfunction

   initial begin
      failures    = 0;
      closes_seen = 0;
      cells_cfg   = 17'd65536;
      line_cfg    = 17'd256;
      plane_cfg   = 17'd65536;
      total_sum   = '0;
      for (int i = 0; i < voa_pkg::GRID_CELLS; i++) begin
         touched[i] = 1'b0;
         hist[i]    = '0;
      end
   end

   assign outstanding = expected_results.size();

   always @(posedge clock) begin
      voxel_result_type got, want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               voa_pkg::CSR_CELLS: cells_cfg = csr_pwdata[16:0];
               voa_pkg::CSR_LINE:  line_cfg  = csr_pwdata[16:0];
               voa_pkg::CSR_PLANE: plane_cfg = csr_pwdata[16:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tuser;
            got.index    = rsp_tdata[15:0];
            got.count    = rsp_tdata[47:16];
            got.distinct = rsp_tdata[60:48];
            got.total    = rsp_tdata[108:61];
            if (got.status == voa_pkg::STS_CLOSE) closes_seen++;
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result transaction: status %0d index %0d",
                           got.status, got.index);
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  failures++;
                  if (failures <= 10)
                     $display({"result mismatch: expected st=%0d idx=%0d cnt=%0d dist=%0d ",
                               "tot=%0d, got st=%0d idx=%0d cnt=%0d dist=%0d tot=%0d"},
                              want.status, want.index, want.count, want.distinct,
                              want.total, got.status, got.index, got.count,
                              got.distinct, got.total);
               end
            end
         end
         if (req_tvalid && req_tready && req_tuser != voa_pkg::REQ_UNUSED)
            expected_results.insert(expected_results.size(),
                                    predict_voxel(req_tuser, req_tdata));
      end
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the voxel occupancy accumulator: directed marks, rejects,
// reads and cycle closes, register extremes, then random traffic over
// several grid geometries; both streams stall at random until the last phase.
// ----------------------------------------------------------------------------
module testbench;

   localparam int         RUN_LIMIT  = 1500000;

   logic          clock, reset;
   logic          req_tvalid, req_tready;
   logic [63:0]   req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid, rsp_tready;
   logic [111:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          csr_psel, csr_penable, csr_pwrite;
   logic [voa_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0]   csr_pwdata, csr_prdata;
   logic          csr_pready;

   int  outstanding, failures, closes_seen;
   int  cycles, sent;
   int  stall_left;
   bit  calm;
   int  udim, vdim, tdim;

   voxel_occupancy_accumulator_top DUT (.*);

   voa_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .outstanding, .failures, .closes_seen
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("[voxel_occupancy_accumulator_top] ERROR");
         $finish;
      end
   end

   // result-side back pressure in random bursts
   always @(posedge clock) begin
      if (calm || reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(logic [1:0] reg_idx, logic [16:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= {15'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_grid(logic [16:0] cells, logic [16:0] line, logic [16:0] plane);
      req_tvalid <= 1'b0;
      drain_results();
      csr_write(voa_pkg::CSR_CELLS, cells);
      csr_write(voa_pkg::CSR_LINE, line);
      csr_write(voa_pkg::CSR_PLANE, plane);
   endtask

   task automatic send_voxel(logic [1:0] kind, logic [15:0] u, logic [15:0] v,
                             logic [15:0] t, logic [15:0] ri);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {ri, t, v, u};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic random_voxel();
      int r;
      logic [15:0] u, v, t, ri;
      r  = $urandom_range(0, 99);
      u  = 16'($urandom_range(0, udim));
      v  = 16'($urandom_range(0, vdim));
      t  = 16'($urandom_range(0, tdim));
      ri = 16'($urandom_range(0, 600));
      if ($urandom_range(0, 9) == 0) begin
         u  = 16'($urandom);
         v  = 16'($urandom);
         t  = 16'($urandom);
         ri = 16'($urandom);
      end
      if (r < 4)       send_voxel(voa_pkg::REQ_UNUSED, u, v, t, ri);
      else if (r < 62) send_voxel(voa_pkg::REQ_MARK, u, v, t, ri);
      else if (r < 74) send_voxel(voa_pkg::REQ_CLOSE, u, v, t, ri);
      else             send_voxel(voa_pkg::REQ_READ, u, v, t, ri);
   endtask

   initial begin
      int line, vsz;
      cycles      = 0;
      sent        = 0;
      stall_left  = 0;
      calm        = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = voa_pkg::REQ_MARK;
      rsp_tready  = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: default geometry, 256 x 256 planes
      send_voxel(voa_pkg::REQ_CLOSE, 0, 0, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 0, 0, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 0, 0, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 0, 255, 255, 0);
      send_voxel(voa_pkg::REQ_MARK, 16'h8000, 0, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 0, 16'hffff, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 0, 0, 16'h8000, 0);
      send_voxel(voa_pkg::REQ_MARK, 1, 0, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_voxel(voa_pkg::REQ_UNUSED, 0, 0, 0, 0);
      send_voxel(voa_pkg::REQ_CLOSE, 0, 0, 0, 0);
      send_voxel(voa_pkg::REQ_READ, 0, 0, 0, 16'd0);
      send_voxel(voa_pkg::REQ_READ, 0, 0, 0, 16'd65535);
      send_voxel(voa_pkg::REQ_READ, 0, 0, 0, 16'hffff);
      send_voxel(voa_pkg::REQ_CLOSE, 0, 0, 0, 0);

      // extremes of the registers
      set_grid(17'd65536, 17'd65536, 17'd65536);
      send_voxel(voa_pkg::REQ_MARK, 0, 0, 16'h7fff, 0);
      send_voxel(voa_pkg::REQ_MARK, 0, 1, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 1, 0, 0, 0);
      send_voxel(voa_pkg::REQ_CLOSE, 0, 0, 0, 0);
      set_grid(17'd1, 17'd1, 17'd1);
      send_voxel(voa_pkg::REQ_MARK, 0, 0, 0, 0);
      send_voxel(voa_pkg::REQ_MARK, 0, 0, 1, 0);
      send_voxel(voa_pkg::REQ_CLOSE, 0, 0, 0, 0);

      // random traffic over several geometries
      for (int phase = 0; phase < 6; phase++) begin
         line = $urandom_range(1, 16);
         vsz  = $urandom_range(1, 16);
         udim = $urandom_range(1, 5);
         vdim = vsz;
         tdim = line;
         if (phase == 5) calm = 1'b1;
         set_grid((phase == 0) ? 17'd65536 :
                  17'(line * vsz * udim - $urandom_range(0, 3)),
                  17'(line), 17'(line * vsz));
         for (int k = 0; k < 200; k++) random_voxel();
      end
      req_tvalid <= 1'b0;

      drain_results();
      $display("sent %0d request transactions; %0d cycle closes with data seen",
               sent, closes_seen);
      if (failures == 0) begin
         $display("[voxel_occupancy_accumulator_top] OK");
      end else begin
         $display("[voxel_occupancy_accumulator_top] ERROR");
      end
      $finish;
   end

endmodule
